// ----- rtl/matrix3_transform_accumulator_top_macros.svh -----
// assertion helpers for the transform accumulator
`ifndef MATRIX3_TRANSFORM_ACCUMULATOR_TOP_MACROS_SVH
`define MATRIX3_TRANSFORM_ACCUMULATOR_TOP_MACROS_SVH

`ifndef SYNTH
// checked while out of reset
`define M3TA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("m3ta assertion failed");
// checked on every edge, reset included
`define M3TA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("m3ta assertion failed");
`else
`define M3TA_ASSERT(label, prop)
`define M3TA_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/m3ta_pkg.sv -----
package m3ta_pkg;

  // port field widths
  localparam int FIELD_W = 32;
  localparam int CMD_W   = 3;

  // matrix shape
  localparam int DIM     = 3;
  localparam int NELEM   = DIM * DIM;

  // command codes
  localparam logic [CMD_W-1:0] CMD_IDENT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ZERO   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRANS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCALE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SCALAR = 3'd5;

endpackage

// ----- rtl/m3ta_lane.sv -----
// one matrix element: up to three truncated products plus an addend, saturated
module m3ta_lane #(
  parameter int ROW        = 0,
  parameter int COL        = 0,
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic [m3ta_pkg::CMD_W-1:0]   cmd,
  input  logic signed [ELEM_WIDTH-1:0] row_elem [m3ta_pkg::DIM],
  input  logic signed [m3ta_pkg::FIELD_W-1:0] op_col [m3ta_pkg::DIM],
  input  logic signed [m3ta_pkg::FIELD_W-1:0] x_val,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] y_val,
  output logic signed [ELEM_WIDTH-1:0] elem_nxt
);
  import m3ta_pkg::*;

  localparam int PW = ELEM_WIDTH + FIELD_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] ONE_W = SW'(1) <<< FRAC_BITS;

  logic signed [ELEM_WIDTH-1:0] own;
  logic signed [ELEM_WIDTH-1:0] ta [DIM];
  logic signed [FIELD_W-1:0]    tb [DIM];
  logic signed [SW-1:0]         addend;
  logic signed [PW-1:0]         prod [DIM];
  logic signed [PW-1:0]         prod_sh [DIM];
  logic signed [SW-1:0]         sum;
  logic [SW-ELEM_WIDTH:0]       sum_hi;

  assign own = row_elem[COL];

  // operand selection per command
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      ta[i] = '0;
      tb[i] = '0;
    end
    addend = SW'(own);
    unique case (cmd)
      CMD_IDENT: begin
        addend = (ROW == COL) ? ONE_W : '0;
      end
      CMD_ZERO: begin
        addend = '0;
      end
      CMD_MUL: begin
        addend = '0;
        for (int i = 0; i < DIM; i++) begin
          ta[i] = row_elem[i];
          tb[i] = op_col[i];
        end
      end
      CMD_TRANS: begin
        if (COL == 0) begin
          ta[0] = row_elem[DIM-1];
          tb[0] = x_val;
        end else if (COL == 1) begin
          ta[0] = row_elem[DIM-1];
          tb[0] = y_val;
        end
      end
      CMD_SCALE: begin
        if (COL == 0) begin
          addend = '0;
          ta[0]  = own;
          tb[0]  = x_val;
        end else if (COL == 1) begin
          addend = '0;
          ta[0]  = own;
          tb[0]  = y_val;
        end
      end
      CMD_SCALAR: begin
        addend = '0;
        ta[0]  = own;
        tb[0]  = x_val;
      end
      default: begin
        addend = SW'(own);
      end
    endcase
  end

  // exact products, truncated toward minus infinity
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      prod[i]    = PW'(ta[i]) * PW'(tb[i]);
      prod_sh[i] = prod[i] >>> FRAC_BITS;
    end
  end

  assign sum = SW'(prod_sh[0]) + SW'(prod_sh[1]) + SW'(prod_sh[2]) + addend;

  // saturate to the element range
  assign sum_hi = sum[SW-1:ELEM_WIDTH-1];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      elem_nxt = sum[ELEM_WIDTH-1:0];
    end else if (sum[SW-1]) begin
      elem_nxt = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    end else begin
      elem_nxt = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/matrix3_transform_accumulator_top.sv -----
// channel  | handshake           | beat contents
// ---------+---------------------+------------------------------------------
// in       | in_valid / in_stall | cmd, operand matrix, first and second value
// out      | out_valid/out_stall | all nine matrix elements after the command
//
// one beat per cycle sustained while out_stall is low; a command's result is
// on the outputs once its beat has passed the input register and the nine
// parallel lanes have written the matrix register, also the output register.
// synchronous active-low reset loads the identity matrix and empties both
// registers. a stalled result holds the matrix; one more input beat is
// taken into the input register and waits there until the result is taken.
`include "matrix3_transform_accumulator_top_macros.svh"

module matrix3_transform_accumulator_top #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [m3ta_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r0c0,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r0c1,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r0c2,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r1c0,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r1c1,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r1c2,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r2c0,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r2c1,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_op_r2c2,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_first_value,
  input  logic signed [m3ta_pkg::FIELD_W-1:0] in_second_value,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r0c0,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r0c1,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r0c2,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r1c0,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r1c1,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r1c2,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r2c0,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r2c1,
  output logic signed [m3ta_pkg::FIELD_W-1:0] out_res_r2c2
);
  import m3ta_pkg::*;

  // identity diagonal, saturated if 1.0 does not fit
  localparam logic signed [ELEM_WIDTH-1:0] ONE_E =
    (FRAC_BITS < ELEM_WIDTH - 1) ? (ELEM_WIDTH'(1) << FRAC_BITS)
                                 : {1'b0, {(ELEM_WIDTH-1){1'b1}}};

  logic                         in_vld_r, in_vld_nxt;
  logic [CMD_W-1:0]             cmd_r;
  logic [NELEM-1:0][FIELD_W-1:0] op_r;
  logic [FIELD_W-1:0]           x_r;
  logic [FIELD_W-1:0]           y_r;

  logic                         out_vld_r, out_vld_nxt;
  logic [NELEM-1:0][ELEM_WIDTH-1:0] mtx_r;
  logic [NELEM-1:0][ELEM_WIDTH-1:0] mtx_nxt;

  logic adv;

  // input beat moves on when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  assign in_vld_nxt  = (in_valid && !in_stall) ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r    <= in_cmd;
      op_r[0]  <= in_op_r0c0;
      op_r[1]  <= in_op_r0c1;
      op_r[2]  <= in_op_r0c2;
      op_r[3]  <= in_op_r1c0;
      op_r[4]  <= in_op_r1c1;
      op_r[5]  <= in_op_r1c2;
      op_r[6]  <= in_op_r2c0;
      op_r[7]  <= in_op_r2c1;
      op_r[8]  <= in_op_r2c2;
      x_r      <= in_first_value;
      y_r      <= in_second_value;
    end
  end

  // one lane per element
  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      logic signed [ELEM_WIDTH-1:0] row_elem [DIM];
      logic signed [FIELD_W-1:0]    op_col [DIM];
      logic signed [ELEM_WIDTH-1:0] elem_nxt;

      for (genvar j = 0; j < DIM; j++) begin : g_tap
        assign row_elem[j] = $signed(mtx_r[r*DIM + j]);
        assign op_col[j]   = $signed(op_r[j*DIM + c]);
      end

      m3ta_lane #(
        .ROW        (r),
        .COL        (c),
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
      ) u_lane (
        .cmd      (cmd_r),
        .row_elem (row_elem),
        .op_col   (op_col),
        .x_val    ($signed(x_r)),
        .y_val    ($signed(y_r)),
        .elem_nxt (elem_nxt)
      );

      assign mtx_nxt[r*DIM + c] = elem_nxt;
    end
  end

  // matrix state, doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NELEM; k++) begin
        mtx_r[k] <= (k % (DIM + 1) == 0) ? ONE_E : '0;
      end
    end else if (adv) begin
      mtx_r <= mtx_nxt;
    end
  end

  // result beat
  assign out_valid    = out_vld_r;
  assign out_res_r0c0 = FIELD_W'($signed(mtx_r[0]));
  assign out_res_r0c1 = FIELD_W'($signed(mtx_r[1]));
  assign out_res_r0c2 = FIELD_W'($signed(mtx_r[2]));
  assign out_res_r1c0 = FIELD_W'($signed(mtx_r[3]));
  assign out_res_r1c1 = FIELD_W'($signed(mtx_r[4]));
  assign out_res_r1c2 = FIELD_W'($signed(mtx_r[5]));
  assign out_res_r2c0 = FIELD_W'($signed(mtx_r[6]));
  assign out_res_r2c1 = FIELD_W'($signed(mtx_r[7]));
  assign out_res_r2c2 = FIELD_W'($signed(mtx_r[8]));

  // checks
  `M3TA_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> in_vld_r)
  `M3TA_ASSERT(a_adv_gives_result, adv |=> out_vld_r)
  `M3TA_ASSERT(a_matrix_holds, !adv |=> $stable(mtx_r))
  `M3TA_ASSERT(a_free_out_drains_in, (in_vld_r && !out_vld_r) |-> !in_stall)

endmodule
